// ----- hdl/rqsc_pkg.sv -----
// ----------------------------------------------------------------------------
// rqsc_pkg: shared types and helpers for the ring queue slot controller
// Slot count, field widths, operation and status codes, register indexes.
// ----------------------------------------------------------------------------
package rqsc_pkg;

   localparam int SLOTS     = 63;
   localparam int PTR_W     = $clog2(SLOTS);
   localparam int CNT_W     = $clog2(SLOTS + 1);
   localparam int LIMIT_W   = 10;
   localparam int TOTAL_W   = 32;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [1:0] {
      KIND_PUT     = 2'd0,
      KIND_PEEK    = 2'd1,
      KIND_CONSUME = 2'd2,
      KIND_CLEAR   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_DISABLED = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_FULL     = 3'd3,
      ST_BAD      = 3'd4
   } status_type;

   localparam logic [CSR_IDX_W-1:0] CSR_RECORD_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERWRITE    = 2'd1;

   typedef struct packed {
      logic [LIMIT_W-1:0] record_limit;
      logic               overwrite;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic       tail_bad;
   } req_type;

   // Step a pointer by one, wrapping to zero at the capacity.
   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] cap);
      logic [CNT_W:0] n;
      n = {{(CNT_W+1-PTR_W){1'b0}}, p} + {{CNT_W{1'b0}}, 1'b1};
      if (n >= {1'b0, cap}) begin
         return '0;
      end
      return n[PTR_W-1:0];
   endfunction

endpackage

// ----- hdl/rqsc_csr.sv -----
// ----------------------------------------------------------------------------
// rqsc_csr: configuration registers
// Holds the record limit and the full-buffer policy bit.
// ----------------------------------------------------------------------------
module rqsc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rqsc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rqsc_pkg::LIMIT_W-1:0]       csr_wdata,
   output rqsc_pkg::cfg_type                  cfg
);

   rqsc_pkg::cfg_type cfg_ff;
   rqsc_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            rqsc_pkg::CSR_RECORD_LIMIT: cfg_in.record_limit = csr_wdata;
            rqsc_pkg::CSR_OVERWRITE:    cfg_in.overwrite    = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.record_limit <= rqsc_pkg::LIMIT_W'(rqsc_pkg::SLOTS);
         cfg_ff.overwrite    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- hdl/rqsc_core.sv -----
// ----------------------------------------------------------------------------
// rqsc_core: ring pointer state and result register
// Applies one registered request to head, tail, count and put counter.
// ----------------------------------------------------------------------------
module rqsc_core (
   input  logic                               clock,
   input  logic                               reset,
   input  rqsc_pkg::cfg_type                  cfg,
   input  rqsc_pkg::req_type                  req,
   output logic                               rsp_valid,
   output logic [2:0]                         rsp_status,
   output logic [rqsc_pkg::PTR_W-1:0]         rsp_slot,
   output logic                               rsp_dropped,
   output logic [rqsc_pkg::CNT_W-1:0]         rsp_depth,
   output logic [rqsc_pkg::TOTAL_W-1:0]       rsp_write_total
);

   logic [rqsc_pkg::PTR_W-1:0]   head_ff, head_in;
   logic [rqsc_pkg::PTR_W-1:0]   tail_ff, tail_in;
   logic [rqsc_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [rqsc_pkg::TOTAL_W-1:0] total_ff, total_in;

   logic                         valid_ff;
   rqsc_pkg::status_type         status_ff, status_in;
   logic [rqsc_pkg::PTR_W-1:0]   slot_ff, slot_in;
   logic                         dropped_ff, dropped_in;

   logic [rqsc_pkg::CNT_W-1:0]   cap;

   // Capacity is the smaller of the slot count and the configured limit.
   always_comb begin
      if (cfg.record_limit < rqsc_pkg::LIMIT_W'(rqsc_pkg::SLOTS)) begin
         cap = cfg.record_limit[rqsc_pkg::CNT_W-1:0];
      end else begin
         cap = rqsc_pkg::CNT_W'(rqsc_pkg::SLOTS);
      end
   end

   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      total_in   = total_ff;
      status_in  = rqsc_pkg::ST_OK;
      slot_in    = '0;
      dropped_in = 1'b0;

      if (req.kind == rqsc_pkg::KIND_CLEAR) begin
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
         total_in = '0;
      end else if (cap == '0) begin
         status_in = rqsc_pkg::ST_DISABLED;
      end else begin
         // Pull state back inside a lowered limit.
         if (head_ff >= cap) head_in = '0;
         if (tail_ff >= cap) tail_in = '0;
         if (count_ff > cap) count_in = cap;

         case (req.kind)
            rqsc_pkg::KIND_PUT: begin
               if (count_in >= cap && !cfg.overwrite) begin
                  status_in = rqsc_pkg::ST_FULL;
               end else begin
                  if (count_in >= cap) begin
                     // Drop the oldest entry to make room.
                     tail_in    = rqsc_pkg::advance(tail_in, cap);
                     count_in   = count_in - rqsc_pkg::CNT_W'(1);
                     dropped_in = 1'b1;
                  end
                  slot_in  = head_in;
                  head_in  = rqsc_pkg::advance(head_in, cap);
                  count_in = count_in + rqsc_pkg::CNT_W'(1);
                  total_in = total_ff + rqsc_pkg::TOTAL_W'(1);
               end
            end
            rqsc_pkg::KIND_PEEK: begin
               if (count_in == '0) begin
                  status_in = rqsc_pkg::ST_EMPTY;
               end else begin
                  slot_in = tail_in;
                  if (req.tail_bad) begin
                     status_in  = rqsc_pkg::ST_BAD;
                     tail_in    = rqsc_pkg::advance(tail_in, cap);
                     count_in   = count_in - rqsc_pkg::CNT_W'(1);
                     dropped_in = 1'b1;
                  end
               end
            end
            rqsc_pkg::KIND_CONSUME: begin
               if (count_in == '0) begin
                  status_in = rqsc_pkg::ST_EMPTY;
               end else begin
                  tail_in  = rqsc_pkg::advance(tail_in, cap);
                  count_in = count_in - rqsc_pkg::CNT_W'(1);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         total_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= req.valid;
         if (req.valid) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
            total_ff <= total_in;
         end
      end
   end

   // Result payload, loaded with each request.
   always_ff @(posedge clock) begin
      if (req.valid) begin
         status_ff  <= status_in;
         slot_ff    <= slot_in;
         dropped_ff <= dropped_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_slot        = slot_ff;
   assign rsp_dropped     = dropped_ff;
   assign rsp_depth       = count_ff;
   assign rsp_write_total = total_ff;

endmodule

// ----- hdl/ring_queue_slot_controller.sv -----
// ----------------------------------------------------------------------------
// ring_queue_slot_controller: head/tail/count keeper for an external ring
// Path: a request taken into the request register is answered from the result register.
// Throughput: one request per cycle, busy is low whenever reset is low.
// Rate is set by the single pass from the request register to the result
// register through the pointer update logic.
// Reset: synchronous, clears pointers, count, put counter and the pipeline;
// limit returns to 63, overwrite bit to 0. The receiver cannot stall.
// ----------------------------------------------------------------------------
module ring_queue_slot_controller (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_kind,
   input  logic                               req_tail_bad,
   output logic                               rsp_valid,
   output logic [2:0]                         rsp_status,
   output logic [rqsc_pkg::PTR_W-1:0]         rsp_slot,
   output logic                               rsp_dropped,
   output logic [rqsc_pkg::CNT_W-1:0]         rsp_depth,
   output logic [rqsc_pkg::TOTAL_W-1:0]       rsp_write_total,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rqsc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rqsc_pkg::LIMIT_W-1:0]       csr_wdata
);

   rqsc_pkg::cfg_type cfg;
   rqsc_pkg::req_type req_ff;
   rqsc_pkg::req_type req_in;

   assign busy = reset;

   always_comb begin
      req_in.valid    = start && !busy;
      req_in.kind     = rqsc_pkg::kind_type'(req_kind);
      req_in.tail_bad = req_tail_bad;
   end

   // Request register in front of the update logic.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_ff.valid <= 1'b0;
      end else begin
         req_ff.valid <= req_in.valid;
      end
      req_ff.kind     <= req_in.kind;
      req_ff.tail_bad <= req_in.tail_bad;
   end

   rqsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rqsc_core u_core (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req             (req_ff),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .rsp_dropped     (rsp_dropped),
      .rsp_depth       (rsp_depth),
      .rsp_write_total (rsp_write_total)
   );

   // Every accepted request is answered once it has passed the request and result registers.
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("request not answered");

   // A discard only comes with a successful put or a bad-record peek.
   a_drop_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_dropped) |->
         (rsp_status == rqsc_pkg::ST_OK || rsp_status == rqsc_pkg::ST_BAD))
      else $error("drop flagged on a failed request");

   // A rejected put reports slot zero and no drop, and leaves the put counter alone.
   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == rqsc_pkg::ST_FULL) |->
         (rsp_slot == '0 && !rsp_dropped && $stable(rsp_write_total)))
      else $error("rejected put changed state");

   // The held count never exceeds the slot count.
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_depth <= rqsc_pkg::CNT_W'(rqsc_pkg::SLOTS)))
      else $error("depth beyond slot count");

endmodule
